### sv/caldc_pkg.sv
// caldc_pkg: shared types and constants of the calendar day counter.
// No dependencies; imported by caldc_rem, calendar_day_counter and tb_top.
package caldc_pkg;

  // Field widths fixed by the item format
  localparam int CMD_W    = 2;
  localparam int MONTH_W  = 5;
  localparam int BASE_W   = 10;
  localparam int SLOT_W   = 2;
  localparam int PERIOD_W = 16;
  localparam int YEAR_W   = 16;
  localparam int YMAG_W   = 17;   // magnitude of a 16-bit signed year
  localparam int DIM_W    = 11;
  localparam int DBM_W    = 14;
  localparam int DIY_W    = 15;
  localparam int MCNT_W   = 5;

  // Steps of the remainder unit, one dividend bit each
  localparam int REM_STEPS = YMAG_W;
  localparam int STEP_W    = $clog2(REM_STEPS + 1);

  localparam logic [DBM_W-1:0] DBM_MAX = '1;
  localparam logic [DIY_W-1:0] DIY_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_BASE  = 2'd0,
    CMD_RULE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LRD,
    ST_RULE,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } state_t;

  // Status of the remainder unit toward the sequencer
  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_sts_t;

endpackage

### sv/caldc_rem.sv
// caldc_rem: restoring remainder unit, one dividend bit per cycle.
// Tells whether a year magnitude is a multiple of a leap period. Uses caldc_pkg.
module caldc_rem (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [caldc_pkg::YMAG_W-1:0]   dividend,
  input  logic [caldc_pkg::PERIOD_W-1:0] divisor,
  output caldc_pkg::rem_sts_t            sts
);
  import caldc_pkg::*;

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [YMAG_W-1:0]   rem_r, rem_nxt;
  logic [YMAG_W-1:0]   q_r, q_nxt;
  logic [PERIOD_W-1:0] div_r, div_nxt;
  logic [YMAG_W-1:0]   trial;

  // The partial remainder stays below the divisor, so its top bit is spare
  assign trial = {rem_r[YMAG_W-2:0], q_r[YMAG_W-1]};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    div_nxt  = div_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      q_nxt   = dividend;
      div_nxt = divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial - {1'b0, div_r};
      end else begin
        rem_nxt = trial;
      end
      q_nxt   = {q_r[YMAG_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(REM_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    div_r <= div_nxt;
  end

  assign sts.done     = done_r;
  assign sts.rem_zero = (rem_r == '0);

endmodule

### sv/calendar_day_counter.sv
// calendar_day_counter: programmable calendar table with base days and leap rules.
// Depends on caldc_pkg and caldc_rem.
//
// Write items (base days, leap rule) give no result. A query item walks every month up
// to month_count, capped at MAX_MONTHS, and every leap rule of those months, reading
// both tables from synchronous memories, and returns one result strobed on out_valid
// for one cycle. Each enabled rule is run in the shared bit-serial remainder unit
// (17 steps). busy stays high until the result has been issued.
// Results cannot be held off by the receiver. Both tables read as zero after reset.
module calendar_day_counter #(
  parameter int MAX_MONTHS      = 16,
  parameter int RULES_PER_MONTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [caldc_pkg::CMD_W-1:0]     in_command,
  input  logic [caldc_pkg::MONTH_W-1:0]   in_month,
  input  logic [caldc_pkg::BASE_W-1:0]    in_base_days,
  input  logic [caldc_pkg::SLOT_W-1:0]    in_rule_slot,
  input  logic [caldc_pkg::PERIOD_W-1:0]  in_period,
  input  logic signed [caldc_pkg::YEAR_W-1:0] in_year,
  // result channel
  output logic                            out_valid,
  output logic [caldc_pkg::DIM_W-1:0]     out_days_in_month,
  output logic [caldc_pkg::DBM_W-1:0]     out_days_before_month,
  output logic [caldc_pkg::DIY_W-1:0]     out_days_in_year,
  output logic                            out_month_valid,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import caldc_pkg::*;

  localparam int LEAP_DEPTH = MAX_MONTHS * RULES_PER_MONTH;
  localparam int MI_W  = (MAX_MONTHS > 1) ? $clog2(MAX_MONTHS) : 1;
  localparam int RI_W  = (RULES_PER_MONTH > 1) ? $clog2(RULES_PER_MONTH) : 1;
  localparam int LA_W  = (LEAP_DEPTH > 1) ? $clog2(LEAP_DEPTH) : 1;
  localparam int N_W   = $clog2(MAX_MONTHS + 1);
  localparam int SUM_W = $clog2(MAX_MONTHS * (1023 + RULES_PER_MONTH) + 1);

  // ---------------- configuration ----------------
  logic [MCNT_W-1:0] month_count_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(month_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_count_r <= '0;
    end else if (cfg_wr) begin
      month_count_r <= pwdata[MCNT_W-1:0];
    end
  end

  // ---------------- control registers ----------------
  state_t              state_r, state_nxt;
  logic [MONTH_W-1:0]  mon_r, mon_nxt;
  logic [N_W-1:0]      n_r, n_nxt;
  logic [YMAG_W-1:0]   ymag_r, ymag_nxt;
  logic [MI_W-1:0]     i_r, i_nxt;
  logic [RI_W-1:0]     r_r, r_nxt;
  logic [DIM_W-1:0]    day_r, day_nxt;
  logic [DIM_W-1:0]    dim_r, dim_nxt;
  logic [SUM_W-1:0]    tot_r, tot_nxt;
  logic [SUM_W-1:0]    bef_r, bef_nxt;
  logic                valid_r, valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DIM_W-1:0]    out_dim_r, out_dim_nxt;
  logic [DBM_W-1:0]    out_dbm_r, out_dbm_nxt;
  logic [DIY_W-1:0]    out_diy_r, out_diy_nxt;
  logic                out_mv_r, out_mv_nxt;

  logic                accept;
  logic                wr_month_ok;
  logic                base_we, leap_we;
  logic [MI_W-1:0]     base_wa;
  logic [LA_W-1:0]     leap_wa, leap_ra;
  logic [N_W-1:0]      n_eff;
  logic [YMAG_W-1:0]   ymag_in;
  logic                div_start;
  rem_sts_t            rem_sts;

  // ---------------- tables ----------------
  logic [BASE_W-1:0]   base_mem [MAX_MONTHS];
  logic [PERIOD_W-1:0] leap_mem [LEAP_DEPTH];
  logic [MAX_MONTHS-1:0] base_vld_r;
  logic [LEAP_DEPTH-1:0] leap_vld_r;
  logic [BASE_W-1:0]   base_q;
  logic [PERIOD_W-1:0] leap_q;
  logic                base_vq, leap_vq;
  logic [BASE_W-1:0]   base_val;
  logic [PERIOD_W-1:0] leap_val;

  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r != ST_IDLE);
  assign wr_month_ok = (in_month != '0) && (32'(in_month) <= MAX_MONTHS);
  assign base_we     = accept && (in_command == CMD_BASE) && wr_month_ok;
  assign leap_we     = accept && (in_command == CMD_RULE) && wr_month_ok &&
                       (32'(in_rule_slot) < RULES_PER_MONTH);
  assign base_wa     = MI_W'(32'(in_month) - 1);
  assign leap_wa     = LA_W'((32'(in_month) - 1) * RULES_PER_MONTH + 32'(in_rule_slot));
  assign leap_ra     = LA_W'(32'(i_r) * RULES_PER_MONTH + 32'(r_r));

  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[base_wa] <= in_base_days;
    end
    base_q <= base_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (leap_we) begin
      leap_mem[leap_wa] <= in_period;
    end
    leap_q <= leap_mem[leap_ra];
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_vld_r <= '0;
      leap_vld_r <= '0;
      base_vq    <= 1'b0;
      leap_vq    <= 1'b0;
    end else begin
      if (base_we) begin
        base_vld_r[base_wa] <= 1'b1;
      end
      if (leap_we) begin
        leap_vld_r[leap_wa] <= 1'b1;
      end
      base_vq <= base_vld_r[i_r];
      leap_vq <= leap_vld_r[leap_ra];
    end
  end

  assign base_val = base_vq ? base_q : '0;
  assign leap_val = leap_vq ? leap_q : '0;

  // ---------------- query setup ----------------
  assign n_eff   = (32'(month_count_r) > MAX_MONTHS) ? N_W'(MAX_MONTHS)
                                                      : N_W'(month_count_r);
  assign ymag_in = in_year[YEAR_W-1] ? YMAG_W'(18'h10000 - 18'(unsigned'(in_year)))
                                     : YMAG_W'(unsigned'(in_year));

  caldc_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ymag_r),
    .divisor  (leap_val),
    .sts      (rem_sts)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    mon_nxt       = mon_r;
    n_nxt         = n_r;
    ymag_nxt      = ymag_r;
    i_nxt         = i_r;
    r_nxt         = r_r;
    day_nxt       = day_r;
    dim_nxt       = dim_r;
    tot_nxt       = tot_r;
    bef_nxt       = bef_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    out_dim_nxt   = out_dim_r;
    out_dbm_nxt   = out_dbm_r;
    out_diy_nxt   = out_diy_r;
    out_mv_nxt    = out_mv_r;
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_QUERY)) begin
          mon_nxt   = in_month;
          n_nxt     = n_eff;
          ymag_nxt  = ymag_in;
          i_nxt     = '0;
          r_nxt     = '0;
          dim_nxt   = '0;
          tot_nxt   = '0;
          bef_nxt   = '0;
          valid_nxt = (in_month != '0) && (32'(in_month) <= 32'(n_eff));
          state_nxt = (n_eff == '0) ? ST_DONE : ST_LRD;
        end
      end
      ST_LRD: begin
        // table reads for month i, rule r are in flight
        state_nxt = ST_RULE;
      end
      ST_RULE: begin
        if (r_r == '0) begin
          day_nxt = DIM_W'(base_val);
        end
        if (leap_val != '0) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (32'(r_r) == RULES_PER_MONTH - 1) begin
          r_nxt     = '0;
          state_nxt = ST_ACC;
        end else begin
          r_nxt     = r_r + 1'b1;
          state_nxt = ST_LRD;
        end
      end
      ST_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.rem_zero) begin
            day_nxt = day_r + 1'b1;
          end
          if (32'(r_r) == RULES_PER_MONTH - 1) begin
            r_nxt     = '0;
            state_nxt = ST_ACC;
          end else begin
            r_nxt     = r_r + 1'b1;
            state_nxt = ST_LRD;
          end
        end
      end
      ST_ACC: begin
        tot_nxt = tot_r + SUM_W'(day_r);
        if (valid_r && (32'(i_r) + 1 < 32'(mon_r))) begin
          bef_nxt = bef_r + SUM_W'(day_r);
        end
        if (valid_r && (32'(i_r) + 1 == 32'(mon_r))) begin
          dim_nxt = day_r;
        end
        if (32'(i_r) + 1 == 32'(n_r)) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_LRD;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_dim_nxt   = dim_r;
        out_dbm_nxt   = (32'(bef_r) > 32'(DBM_MAX)) ? DBM_MAX : DBM_W'(bef_r);
        out_diy_nxt   = (32'(tot_r) > 32'(DIY_MAX)) ? DIY_MAX : DIY_W'(tot_r);
        out_mv_nxt    = valid_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mon_r     <= mon_nxt;
    n_r       <= n_nxt;
    ymag_r    <= ymag_nxt;
    i_r       <= i_nxt;
    r_r       <= r_nxt;
    day_r     <= day_nxt;
    dim_r     <= dim_nxt;
    tot_r     <= tot_nxt;
    bef_r     <= bef_nxt;
    valid_r   <= valid_nxt;
    out_dim_r <= out_dim_nxt;
    out_dbm_r <= out_dbm_nxt;
    out_diy_r <= out_diy_nxt;
    out_mv_r  <= out_mv_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_days_in_month     = out_dim_r;
  assign out_days_before_month = out_dbm_r;
  assign out_days_in_year      = out_diy_r;
  assign out_month_valid       = out_mv_r;

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking testbench of calendar_day_counter, driving the command and
// APB ports and predicting every query result from a mirror of the calendar tables.
// Depends on caldc_pkg and the calendar_day_counter RTL.
`timescale 1ns / 100ps

module tb_top;
  import caldc_pkg::*;

  localparam int MAX_MONTHS      = 16;
  localparam int RULES_PER_MONTH = 4;
  // Bound on the longest query with the default sizes
  localparam int QUERY_CYCLES_MAX = 1298;
  localparam int QUIET_CYCLES     = QUERY_CYCLES_MAX + 66;
  localparam int STALL_LIMIT      = 20000;
  localparam int DIM_MAX          = (1 << DIM_W) - 1;
  localparam int DBM_MAX_I        = (1 << DBM_W) - 1;
  localparam int DIY_MAX_I        = (1 << DIY_W) - 1;
  localparam int PHASES           = 7;
  localparam int ITEMS_PER_PHASE  = 74;

  typedef struct packed {
    cmd_t                     cmd;
    logic [MONTH_W-1:0]       month;
    logic [BASE_W-1:0]        base;
    logic [SLOT_W-1:0]        slot;
    logic [PERIOD_W-1:0]      period;
    logic signed [YEAR_W-1:0] year;
  } cal_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] dim;
    logic [DBM_W-1:0] dbm;
    logic [DIY_W-1:0] diy;
    logic             valid;
  } day_count_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [CMD_W-1:0]          in_command;
  logic [MONTH_W-1:0]        in_month;
  logic [BASE_W-1:0]         in_base_days;
  logic [SLOT_W-1:0]         in_rule_slot;
  logic [PERIOD_W-1:0]       in_period;
  logic signed [YEAR_W-1:0]  in_year;
  logic                      out_valid;
  logic [DIM_W-1:0]          out_days_in_month;
  logic [DBM_W-1:0]          out_days_before_month;
  logic [DIY_W-1:0]          out_days_in_year;
  logic                      out_month_valid;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [2:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  // Mirror of the calendar state
  logic [BASE_W-1:0]   month_days_tbl [MAX_MONTHS];
  logic [PERIOD_W-1:0] leap_period_tbl [MAX_MONTHS*RULES_PER_MONTH];
  logic [MCNT_W-1:0]   month_count_mirror;

  cal_item_t  queued_commands[$];
  day_count_t awaited_day_counts[$];
  int         mismatch_count;
  int         gap_pct;
  int         stall_cycles;

  calendar_day_counter #(
    .MAX_MONTHS      (MAX_MONTHS),
    .RULES_PER_MONTH (RULES_PER_MONTH)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_command            (in_command),
    .in_month              (in_month),
    .in_base_days          (in_base_days),
    .in_rule_slot          (in_rule_slot),
    .in_period             (in_period),
    .in_year               (in_year),
    .out_valid             (out_valid),
    .out_days_in_month     (out_days_in_month),
    .out_days_before_month (out_days_before_month),
    .out_days_in_year      (out_days_in_year),
    .out_month_valid       (out_month_valid),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic day_count_t predict_day_counts(input logic [MONTH_W-1:0] month,
                                                    input logic [YEAR_W-1:0] year);
    logic [YMAG_W-1:0] mag;
    logic [YMAG_W-1:0] period;
    int               n;
    int               d;
    int               total;
    int               before_sum;
    int               dim;
    bit               valid;
    day_count_t       res;
    mag = year[YEAR_W-1] ? (17'h10000 - {1'b0, year}) : {1'b0, year};
    n = (month_count_mirror > MAX_MONTHS) ? MAX_MONTHS : month_count_mirror;
    valid = (month >= 1) && (month <= n);
    total = 0;
    before_sum = 0;
    dim = 0;
    for (int i = 0; i < n; i++) begin
      d = month_days_tbl[i];
      for (int r = 0; r < RULES_PER_MONTH; r++) begin
        period = {1'b0, leap_period_tbl[i*RULES_PER_MONTH + r]};
        if (period != 0 && (mag % period) == 0) d++;
      end
      if (valid && i + 1 < month) before_sum += d;
      if (valid && i + 1 == month) dim = d;
      total += d;
    end
    // saturate to field width
    res.dim   = (dim > DIM_MAX) ? DIM_MAX[DIM_W-1:0] : dim[DIM_W-1:0];
    res.dbm   = (before_sum > DBM_MAX_I) ? DBM_MAX : before_sum[DBM_W-1:0];
    res.diy   = (total > DIY_MAX_I) ? DIY_MAX : total[DIY_W-1:0];
    res.valid = valid;
    return res;
  endfunction

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      mismatch_count++;
    end
  endtask

  // Driver: present the next item once the previous one has been taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (queued_commands.size() > 0 && $urandom_range(99) >= gap_pct) begin
        start        <= 1'b1;
        in_command   <= queued_commands[0].cmd;
        in_month     <= queued_commands[0].month;
        in_base_days <= queued_commands[0].base;
        in_rule_slot <= queued_commands[0].slot;
        in_period    <= queued_commands[0].period;
        in_year      <= queued_commands[0].year;
        void'(queued_commands.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: update the mirror on each accepted item and check results
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_day_counts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual dim=%0d dbm=%0d diy=%0d v=%0d",
                 $time, out_days_in_month, out_days_before_month, out_days_in_year,
                 out_month_valid);
        mismatch_count++;
      end else begin
        check_field("days_in_month", awaited_day_counts[0].dim, out_days_in_month);
        check_field("days_before_month", awaited_day_counts[0].dbm, out_days_before_month);
        check_field("days_in_year", awaited_day_counts[0].diy, out_days_in_year);
        check_field("month_valid", awaited_day_counts[0].valid, out_month_valid);
        void'(awaited_day_counts.pop_front());
      end
    end
    if (rst_n && start && !busy) begin
      case (in_command)
        CMD_BASE: begin
          if (in_month >= 1 && in_month <= MAX_MONTHS)
            month_days_tbl[in_month - 1] = in_base_days;
        end
        CMD_RULE: begin
          if (in_month >= 1 && in_month <= MAX_MONTHS && in_rule_slot < RULES_PER_MONTH)
            leap_period_tbl[(in_month - 1) * RULES_PER_MONTH + in_rule_slot] = in_period;
        end
        CMD_QUERY: begin
          awaited_day_counts.push_back(predict_day_counts(in_month, in_year));
        end
        default: ;
      endcase
    end
    if (psel && penable && !pwrite) begin
      check_field("month_count readback", month_count_mirror, prdata[MCNT_W-1:0]);
    end
  end

  // Watchdog: stop when nothing has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic write_month_count(input logic [MCNT_W-1:0] value);
    logic [31:0] word;
    word = $urandom;
    word[MCNT_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    month_count_mirror = value;
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_item(input cmd_t cmd, input int month, input int base, input int slot,
                            input int period, input int year);
    cal_item_t it;
    it.cmd    = cmd;
    it.month  = MONTH_W'(month);
    it.base   = BASE_W'(base);
    it.slot   = SLOT_W'(slot);
    it.period = PERIOD_W'(period);
    it.year   = YEAR_W'(year);
    queued_commands.push_back(it);
  endtask

  // Hold until every item is taken and answered, then let the block settle
  task automatic wait_for_quiet();
    while (queued_commands.size() > 0 || awaited_day_counts.size() > 0 || start || busy)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  function automatic cal_item_t random_command();
    cal_item_t it;
    int        sel;
    it.month  = MONTH_W'($urandom);
    it.base   = BASE_W'($urandom);
    it.slot   = SLOT_W'($urandom);
    it.period = PERIOD_W'($urandom);
    it.year   = YEAR_W'($urandom);
    sel = $urandom_range(99);
    if (sel < 4) begin
      it.cmd = CMD_NONE;
    end else if (sel < 36) begin
      it.cmd = CMD_BASE;
      if ($urandom_range(9) != 0) it.month = MONTH_W'($urandom_range(1, MAX_MONTHS));
      case ($urandom_range(4))
        0: it.base = '0;
        1: it.base = '1;
        2: it.base = BASE_W'($urandom_range(28, 31));
        default: ;
      endcase
    end else if (sel < 66) begin
      it.cmd = CMD_RULE;
      if ($urandom_range(9) != 0) it.month = MONTH_W'($urandom_range(1, MAX_MONTHS));
      case ($urandom_range(6))
        0: it.period = '0;
        1: it.period = PERIOD_W'($urandom_range(1, 8));
        2: it.period = PERIOD_W'(100);
        3: it.period = PERIOD_W'(400);
        4: it.period = '1;
        default: ;
      endcase
    end else begin
      it.cmd = CMD_QUERY;
      if ($urandom_range(9) != 0) it.month = MONTH_W'($urandom_range(1, MAX_MONTHS));
      case ($urandom_range(5))
        0: it.year = YEAR_W'($urandom_range(0, 128) - 64);
        1: it.year = YEAR_W'($urandom_range(0, 80) * 400 * ($urandom_range(1) ? 1 : -1));
        2: it.year = YEAR_W'($urandom_range(0, 300) * 100 * ($urandom_range(1) ? 1 : -1));
        3: it.year = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        default: ;
      endcase
    end
    return it;
  endfunction

  initial begin
    int        phase_mcount[PHASES];
    int        phase_gap[PHASES];
    cal_item_t it;
    int        n;
    phase_mcount = '{31, 0, 1, 12, 5, 17, 16};
    phase_gap    = '{33, 33, 80, 80, 80, 0, 0};
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_NONE;
    in_month = '0;
    in_base_days = '0;
    in_rule_slot = '0;
    in_period = '0;
    in_year = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_count = 0;
    gap_pct = 33;
    month_count_mirror = '0;
    for (int i = 0; i < MAX_MONTHS; i++) month_days_tbl[i] = '0;
    for (int i = 0; i < MAX_MONTHS*RULES_PER_MONTH; i++) leap_period_tbl[i] = '0;
    phase_mcount[4] = $urandom_range(2, 15);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_month_count(MCNT_W'(MAX_MONTHS));
    // tables read as zero after reset
    queue_item(CMD_QUERY, 1, 0, 0, 0, 0);
    queue_item(CMD_BASE, 1, 1023, 3, 65535, -1);
    queue_item(CMD_BASE, 16, 0, 0, 0, 0);
    queue_item(CMD_BASE, 2, 31, 0, 0, 0);
    queue_item(CMD_BASE, 0, 500, 0, 0, 0);     // month zero: drop
    queue_item(CMD_BASE, 17, 600, 0, 0, 0);    // past the table: drop
    queue_item(CMD_BASE, 31, 700, 0, 0, 0);
    queue_item(CMD_RULE, 1, 0, 3, 65535, 0);
    queue_item(CMD_RULE, 1, 0, 0, 0, 0);       // disabled rule
    queue_item(CMD_RULE, 16, 0, 2, 4, 0);
    queue_item(CMD_RULE, 2, 0, 1, 1, 0);
    queue_item(CMD_RULE, 0, 0, 1, 2, 0);
    queue_item(CMD_RULE, 20, 0, 3, 2, 0);
    queue_item(CMD_NONE, 3, 1023, 3, 65535, 32767);  // unused command
    queue_item(CMD_QUERY, 16, 0, 0, 0, -32768);
    queue_item(CMD_QUERY, 1, 0, 0, 0, 32767);
    queue_item(CMD_QUERY, 2, 0, 0, 0, 0);
    queue_item(CMD_QUERY, 16, 0, 0, 0, -4);
    queue_item(CMD_QUERY, 16, 0, 0, 0, 4);
    queue_item(CMD_QUERY, 1, 0, 0, 0, -1);
    queue_item(CMD_QUERY, 0, 0, 0, 0, 8);      // invalid month
    queue_item(CMD_QUERY, 17, 0, 0, 0, 8);
    queue_item(CMD_QUERY, 31, 1023, 3, 65535, -32767);
    wait_for_quiet();

    for (int ph = 0; ph < PHASES; ph++) begin
      gap_pct = phase_gap[ph];
      write_month_count(MCNT_W'(phase_mcount[ph]));
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        it = random_command();
        queued_commands.push_back(it);
        // ignored items do not count
        if (it.cmd != CMD_NONE &&
            (it.cmd == CMD_QUERY || (it.month >= 1 && it.month <= MAX_MONTHS)))
          n++;
      end
      wait_for_quiet();
    end

    if (awaited_day_counts.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0, actual %0d", $time,
               awaited_day_counts.size(), awaited_day_counts.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
